>>> src/jsu_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the JSON string unescaper.
// Depends on nothing; used by jsu_decode, jsu_outq and the top level.
package jsu_pkg;

    typedef enum logic [1:0] {
        MODE_NORMAL  = 2'd0,
        MODE_ESCAPE  = 2'd1,
        MODE_HEX     = 2'd2,
        MODE_HEX_BAD = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_BYTE   = 2'd0,
        ST_CLOSED = 2'd1,
        ST_ERROR  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ERR_NONE    = 3'd0,
        ERR_CONTROL = 3'd1,
        ERR_ESCAPE  = 3'd2,
        ERR_HEX     = 3'd3,
        ERR_RANGE   = 3'd4,
        ERR_END     = 3'd5
    } err_t;

    typedef struct packed {
        logic [7:0] data;
        status_t    status;
        err_t       err;
        logic       last;
    } result_t;

    localparam int MAX_RES = 3;

    // Results of one input word; res[0] goes out first.
    typedef struct packed {
        logic [1:0]                 count;
        result_t [MAX_RES-1:0]      res;
    } group_t;

    localparam int QDEPTH = 16;
    localparam int PTR_W  = $clog2(QDEPTH);
    localparam int CNT_W  = PTR_W + 1;
    // Highest fill, counting the room held for a word in the decode stage, at which
    // a new word may enter.
    localparam int Q_LIMIT = QDEPTH - MAX_RES;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_DEL    = 8'h7F;

    localparam logic [15:0] CP_SURR_LO = 16'hD800;
    localparam logic [15:0] CP_SURR_HI = 16'hDFFF;
    localparam logic [15:0] CP_NONCHAR = 16'hFFFE;
    localparam logic [15:0] CP_TWO     = 16'h0080;
    localparam logic [15:0] CP_THREE   = 16'h0800;
    localparam logic [7:0]  UTF_CONT   = 8'h80;
    localparam logic [7:0]  UTF_LEAD2  = 8'hC0;
    localparam logic [7:0]  UTF_LEAD3  = 8'hE0;

    // Returns {valid, value} for an ASCII hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    function automatic result_t mk_result(input logic [7:0] data, input status_t status,
                                          input err_t err, input logic last);
        result_t r;
        r.data   = data;
        r.status = status;
        r.err    = err;
        r.last   = last;
        return r;
    endfunction

endpackage

>>> src/json_string_unescaper_top.sv
`timescale 1ns / 1ps
// Top level of the JSON string unescaper: input stream, decoder, result queue.
// Depends on jsu_pkg, jsu_decode and jsu_outq.
//
// Feed the bytes of a JSON string body, one word per cycle, starting after the
// opening quote; set tuser to mark end of stream. Each word is decoded
// combinationally after its input register and gives zero to three result words;
// the first of them is written to the result queue and offered on the output from
// there. Decoded bytes come out in order, UTF-8 lead byte first, then a close or
// error word ends the string and the next input byte starts a new one. The input
// takes one word every cycle as long as the 16-entry result queue has room for
// the word in the decoder plus the incoming one; a downstream that takes one word
// per cycle never throttles the input.
module json_string_unescaper_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic [0:0]  s_axis_tuser,   // [0] stream_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [10:8] error_code, rest zero
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    output logic        m_axis_tlast
);

    jsu_pkg::group_t                   group;
    logic [jsu_pkg::CNT_W-1:0]         q_count;
    jsu_pkg::result_t                  out_res;

    jsu_decode u_decode
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_byte  (s_axis_tdata),
        .in_end   (s_axis_tuser[0]),
        .q_count  (q_count),
        .group    (group)
    );

    jsu_outq u_outq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .group     (group),
        .count     (q_count),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = {5'b00000, out_res.err, out_res.data};
    assign m_axis_tuser = out_res.status;
    assign m_axis_tlast = out_res.last;

endmodule

>>> src/jsu_decode.sv
`timescale 1ns / 1ps
// Input word register, escape state and the combinational decoder that turns
// one registered word into zero to three results. Depends on jsu_pkg.
module jsu_decode
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [7:0]                 in_byte,
    input  logic                       in_end,
    input  logic [jsu_pkg::CNT_W-1:0]  q_count,
    output jsu_pkg::group_t            group
);

    logic                 busy_reg;
    logic [7:0]           byte_reg;
    logic                 end_reg;
    jsu_pkg::mode_t       mode_reg, mode_next;
    logic [1:0]           hex_cnt_reg, hex_cnt_next;
    logic [15:0]          cp_reg, cp_next;

    logic [4:0]           hv;
    logic                 bad;
    logic [15:0]          acc;
    logic                 accept;

    // Room is reserved for the word in the decode stage and for the one entering.
    assign in_ready = ({1'b0, q_count} + (busy_reg ? (jsu_pkg::CNT_W+1)'(jsu_pkg::MAX_RES)
                       : '0)) <= (jsu_pkg::CNT_W+1)'(jsu_pkg::Q_LIMIT);
    assign accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            mode_reg    <= jsu_pkg::MODE_NORMAL;
            hex_cnt_reg <= 2'd0;
            cp_reg      <= 16'd0;
        end
        else
        begin
            busy_reg    <= accept;
            mode_reg    <= mode_next;
            hex_cnt_reg <= hex_cnt_next;
            cp_reg      <= cp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= in_byte;
            end_reg  <= in_end;
        end
    end

    always_comb
    begin
        mode_next    = mode_reg;
        hex_cnt_next = hex_cnt_reg;
        cp_next      = cp_reg;
        group.count  = 2'd0;
        group.res    = '0;
        hv           = jsu_pkg::hex_value(byte_reg);
        bad          = (mode_reg == jsu_pkg::MODE_HEX_BAD) || !hv[4];
        acc          = hv[4] ? {cp_reg[11:0], hv[3:0]} : cp_reg;

        if (busy_reg)
        begin
            if (end_reg)
            begin
                group.count  = 2'd1;
                group.res[0] = jsu_pkg::mk_result(8'd0, jsu_pkg::ST_ERROR,
                                                  jsu_pkg::ERR_END, 1'b1);
                mode_next    = jsu_pkg::MODE_NORMAL;
                hex_cnt_next = 2'd0;
                cp_next      = 16'd0;
            end
            else
            begin
                unique case (mode_reg)
                    jsu_pkg::MODE_NORMAL:
                    begin
                        if (byte_reg[7:5] == 3'b000 || byte_reg == jsu_pkg::CH_DEL)
                        begin
                            group.count  = 2'd1;
                            group.res[0] = jsu_pkg::mk_result(8'd0, jsu_pkg::ST_ERROR,
                                                              jsu_pkg::ERR_CONTROL, 1'b1);
                        end
                        else if (byte_reg == jsu_pkg::CH_QUOTE)
                        begin
                            group.count  = 2'd1;
                            group.res[0] = jsu_pkg::mk_result(8'd0, jsu_pkg::ST_CLOSED,
                                                              jsu_pkg::ERR_NONE, 1'b1);
                        end
                        else if (byte_reg == jsu_pkg::CH_BSLASH)
                        begin
                            mode_next = jsu_pkg::MODE_ESCAPE;
                        end
                        else
                        begin
                            group.count  = 2'd1;
                            group.res[0] = jsu_pkg::mk_result(byte_reg, jsu_pkg::ST_BYTE,
                                                              jsu_pkg::ERR_NONE, 1'b1);
                        end
                    end
                    jsu_pkg::MODE_ESCAPE:
                    begin
                        group.count = 2'd1;
                        mode_next   = jsu_pkg::MODE_NORMAL;
                        unique case (byte_reg)
                            jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH, jsu_pkg::CH_QUOTE:
                                group.res[0] = jsu_pkg::mk_result(byte_reg, jsu_pkg::ST_BYTE,
                                                                  jsu_pkg::ERR_NONE, 1'b1);
                            jsu_pkg::CH_N:
                                group.res[0] = jsu_pkg::mk_result(8'h0A, jsu_pkg::ST_BYTE,
                                                                  jsu_pkg::ERR_NONE, 1'b1);
                            jsu_pkg::CH_R:
                                group.res[0] = jsu_pkg::mk_result(8'h0D, jsu_pkg::ST_BYTE,
                                                                  jsu_pkg::ERR_NONE, 1'b1);
                            jsu_pkg::CH_T:
                                group.res[0] = jsu_pkg::mk_result(8'h09, jsu_pkg::ST_BYTE,
                                                                  jsu_pkg::ERR_NONE, 1'b1);
                            jsu_pkg::CH_B:
                                group.res[0] = jsu_pkg::mk_result(8'h08, jsu_pkg::ST_BYTE,
                                                                  jsu_pkg::ERR_NONE, 1'b1);
                            jsu_pkg::CH_F:
                                group.res[0] = jsu_pkg::mk_result(8'h0C, jsu_pkg::ST_BYTE,
                                                                  jsu_pkg::ERR_NONE, 1'b1);
                            jsu_pkg::CH_U:
                            begin
                                group.count  = 2'd0;
                                mode_next    = jsu_pkg::MODE_HEX;
                                hex_cnt_next = 2'd0;
                                cp_next      = 16'd0;
                            end
                            default:
                                group.res[0] = jsu_pkg::mk_result(8'd0, jsu_pkg::ST_ERROR,
                                                                  jsu_pkg::ERR_ESCAPE, 1'b1);
                        endcase
                    end
                    default:
                    begin
                        if (hex_cnt_reg != 2'd3)
                        begin
                            hex_cnt_next = hex_cnt_reg + 2'd1;
                            cp_next      = acc;
                            mode_next    = bad ? jsu_pkg::MODE_HEX_BAD : jsu_pkg::MODE_HEX;
                        end
                        else
                        begin
                            mode_next    = jsu_pkg::MODE_NORMAL;
                            hex_cnt_next = 2'd0;
                            cp_next      = 16'd0;
                            if (bad)
                            begin
                                group.count  = 2'd1;
                                group.res[0] = jsu_pkg::mk_result(8'd0, jsu_pkg::ST_ERROR,
                                                                  jsu_pkg::ERR_HEX, 1'b1);
                            end
                            else if ((acc >= jsu_pkg::CP_SURR_LO && acc <= jsu_pkg::CP_SURR_HI)
                                     || acc >= jsu_pkg::CP_NONCHAR)
                            begin
                                group.count  = 2'd1;
                                group.res[0] = jsu_pkg::mk_result(8'd0, jsu_pkg::ST_ERROR,
                                                                  jsu_pkg::ERR_RANGE, 1'b1);
                            end
                            else if (acc < jsu_pkg::CP_TWO)
                            begin
                                group.count  = 2'd1;
                                group.res[0] = jsu_pkg::mk_result(acc[7:0], jsu_pkg::ST_BYTE,
                                                                  jsu_pkg::ERR_NONE, 1'b1);
                            end
                            else if (acc < jsu_pkg::CP_THREE)
                            begin
                                group.count  = 2'd2;
                                group.res[0] = jsu_pkg::mk_result(
                                    jsu_pkg::UTF_LEAD2 | {3'b000, acc[10:6]},
                                    jsu_pkg::ST_BYTE, jsu_pkg::ERR_NONE, 1'b0);
                                group.res[1] = jsu_pkg::mk_result(
                                    jsu_pkg::UTF_CONT | {2'b00, acc[5:0]},
                                    jsu_pkg::ST_BYTE, jsu_pkg::ERR_NONE, 1'b1);
                            end
                            else
                            begin
                                group.count  = 2'd3;
                                group.res[0] = jsu_pkg::mk_result(
                                    jsu_pkg::UTF_LEAD3 | {4'b0000, acc[15:12]},
                                    jsu_pkg::ST_BYTE, jsu_pkg::ERR_NONE, 1'b0);
                                group.res[1] = jsu_pkg::mk_result(
                                    jsu_pkg::UTF_CONT | {2'b00, acc[11:6]},
                                    jsu_pkg::ST_BYTE, jsu_pkg::ERR_NONE, 1'b0);
                                group.res[2] = jsu_pkg::mk_result(
                                    jsu_pkg::UTF_CONT | {2'b00, acc[5:0]},
                                    jsu_pkg::ST_BYTE, jsu_pkg::ERR_NONE, 1'b1);
                            end
                        end
                    end
                endcase
            end
        end
    end

`ifndef SYNTHESIS
    // Every error or close leaves the decoder back in its idle state.
    a_idle_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        (group.count == 2'd1 && group.res[0].status != jsu_pkg::ST_BYTE) |=>
        (mode_reg == jsu_pkg::MODE_NORMAL && hex_cnt_reg == 2'd0 && cp_reg == 16'd0))
        else $error("decoder not idle after close or error");

    // The hex digit counter only runs while a \u escape is open.
    a_hex_cnt_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (hex_cnt_reg != 2'd0) |-> (mode_reg == jsu_pkg::MODE_HEX ||
                                   mode_reg == jsu_pkg::MODE_HEX_BAD))
        else $error("hex digit count outside a unicode escape");
`endif

endmodule

>>> src/jsu_outq.sv
`timescale 1ns / 1ps
// Result queue: takes up to three results per cycle from the decoder and
// hands them out one word per cycle while out_ready is high. Depends on jsu_pkg.
module jsu_outq
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  jsu_pkg::group_t            group,
    output logic [jsu_pkg::CNT_W-1:0]  count,
    output logic                       out_valid,
    input  logic                       out_ready,
    output jsu_pkg::result_t           out_res
);

    jsu_pkg::result_t                  entries_reg [jsu_pkg::QDEPTH];
    logic [jsu_pkg::PTR_W-1:0]         wr_ptr_reg, rd_ptr_reg;
    logic [jsu_pkg::CNT_W-1:0]         count_reg;
    logic                              pop;

    assign count     = count_reg;
    assign out_valid = (count_reg != '0);
    assign out_res   = entries_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + jsu_pkg::PTR_W'(group.count);
            rd_ptr_reg <= rd_ptr_reg + jsu_pkg::PTR_W'(pop);
            count_reg  <= count_reg + jsu_pkg::CNT_W'(group.count) - jsu_pkg::CNT_W'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < jsu_pkg::MAX_RES; i++)
        begin
            if (2'(i) < group.count)
            begin
                entries_reg[wr_ptr_reg + jsu_pkg::PTR_W'(i)] <= group.res[i];
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, count_reg} + {{jsu_pkg::CNT_W{1'b0}}, group.count})
            <= (jsu_pkg::CNT_W+1)'(jsu_pkg::QDEPTH))
        else $error("result queue overflow");

    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg - rd_ptr_reg) == count_reg[jsu_pkg::PTR_W-1:0])
        else $error("queue pointers disagree with fill count");

    // The final result of each group is the only one marked last.
    a_group_last: assert property (@(posedge clk) disable iff (!rst_n)
        (group.count != 2'd0) |->
            (group.res[group.count - 2'd1].last &&
             (group.count == 2'd1 || !group.res[0].last)))
        else $error("last flag misplaced in result group");
`endif

endmodule
